FILE: rtl/core/bdd_pkg.sv
// Package for the byte destuffing deframer: widths, codes and item types.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package bdd_pkg;

  // Field widths fixed by the item format.
  localparam int ByteW = 8;
  localparam int CodeW = 2;
  localparam int LenW  = 11;

  // Saturation limit of the payload counter and the counter width it needs.
  localparam int MaxPayload = 1024;
  localparam int CountW     = $clog2(MaxPayload + 1);

  // Queue between the classifier and the frame engine (power of two).
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Configuration register indexes.
  localparam int CfgIdxW = 1;
  typedef enum logic [CfgIdxW-1:0] {
    REG_FLAG   = 1'b0,
    REG_ESCAPE = 1'b1
  } cfg_reg_t;

  localparam logic [ByteW-1:0] FlagReset   = 8'd126;
  localparam logic [ByteW-1:0] EscapeReset = 8'd125;

  // Verdict codes.
  typedef enum logic [CodeW-1:0] {
    ERR_NONE      = 2'd0,
    ERR_FLAG      = 2'd1,
    ERR_DANGLING  = 2'd2,
    ERR_UNESCAPED = 2'd3
  } err_t;

  // Frame engine phase, one-hot.
  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_BODY  = 3'b010,
    PH_ESC   = 3'b100
  } phase_t;

  // A classified input item as it travels through the queue.
  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic             frame_end;
    logic             is_flag;
    logic             is_esc;
  } item_t;

  // Queue status seen by the frame engine and the top level.
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

FILE: rtl/core/bdd_in_if.sv
// Input channel of the deframer: valid/ready handshake with one received byte.
// Depends on bdd_pkg for the field widths.
`timescale 1ns / 1ps

interface bdd_in_if import bdd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;
  logic             frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

FILE: rtl/core/bdd_out_if.sv
// Result channel of the deframer: valid/ready handshake with data and verdict.
// Depends on bdd_pkg for the field widths.
`timescale 1ns / 1ps

interface bdd_out_if import bdd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             data_valid;
  logic [ByteW-1:0] data_byte;
  logic             frame_done;
  logic             frame_good;
  logic [CodeW-1:0] error_code;
  logic [LenW-1:0]  payload_length;

  modport source (output valid, output data_valid, output data_byte, output frame_done,
                  output frame_good, output error_code, output payload_length,
                  input ready);
  modport sink   (input valid, input data_valid, input data_byte, input frame_done,
                  input frame_good, input error_code, input payload_length,
                  output ready);
endinterface

FILE: rtl/core/byte_destuffing_deframer_unit.sv
// Byte destuffing deframer, top level: front end, item queue and frame engine.
// Each accepted item is written into the queue; when the frame engine takes it, its result is
// registered in the output register and held there until the result channel is ready.
// Throughput: one item per cycle while the result channel is ready, set by the frame engine update.
// Synchronous active-high reset clears the queue, the frame state and the output valid
// flag, and sets the flag and escape registers to 126 and 125.
`timescale 1ns / 1ps

module byte_destuffing_deframer_unit import bdd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ByteW-1:0]   cfg_wdata,
  bdd_in_if.sink             in_ch,
  bdd_out_if.source          out_ch
);

  logic      push;
  logic      pop;
  item_t     push_item;
  item_t     pop_item;
  q_status_t q_status;

  // Classifier and configuration registers.
  bdd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  // Decoupling queue.
  bdd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_status  (q_status)
  );

  // Frame engine and output register.
  bdd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_item (pop_item),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

  // An empty queue stays empty unless an item is accepted.
  assert property (@(posedge clk) disable iff (rst)
    (q_status.empty && !(in_ch.valid && in_ch.ready)) |=> q_status.empty)
    else $error("queue filled without an accepted item");

  // A verdict is good exactly when it carries no error code.
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.frame_done) |->
      (out_ch.frame_good == (out_ch.error_code == ERR_NONE)))
    else $error("frame_good disagrees with error_code");

  // Results that end no frame carry neither verdict nor code.
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.frame_done) |->
      (!out_ch.frame_good && out_ch.error_code == ERR_NONE))
    else $error("verdict given outside a frame end");

  // The closing byte is never passed on as data.
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.frame_done) |-> !out_ch.data_valid)
    else $error("data emitted on a frame end");

endmodule

FILE: rtl/core/bdd_front.sv
// Front end: holds the flag and escape registers, accepts bytes and classifies them.
// Depends on bdd_pkg and bdd_in_if.
`timescale 1ns / 1ps

module bdd_front import bdd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ByteW-1:0]   cfg_wdata,
  bdd_in_if.sink             in_ch,
  input  q_status_t          q_status,
  output logic               push,
  output item_t              push_item
);

  logic [ByteW-1:0] flag_byte;
  logic [ByteW-1:0] escape_byte;

  // Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      flag_byte   <= FlagReset;
      escape_byte <= EscapeReset;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FLAG:   flag_byte   <= cfg_wdata;
        REG_ESCAPE: escape_byte <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Take an item whenever the queue has room.
  assign in_ch.ready = !q_status.full;
  assign push        = in_ch.valid && !q_status.full;

  // Classify the byte against both special values.
  always_comb begin
    push_item.rx_byte   = in_ch.rx_byte;
    push_item.frame_end = in_ch.frame_end;
    push_item.is_flag   = (in_ch.rx_byte == flag_byte);
    push_item.is_esc    = (in_ch.rx_byte == escape_byte);
  end

endmodule

FILE: rtl/core/bdd_queue.sv
// Short queue of classified items between the front end and the frame engine.
// Depends on bdd_pkg.
`timescale 1ns / 1ps

module bdd_queue import bdd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  item_t     push_item,
  input  logic      pop,
  output item_t     pop_item,
  output q_status_t q_status
);

  item_t            slots [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  // Slot storage carries no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      if (push && !pop) begin
        count <= count + QCntW'(1);
      end else if (pop && !push) begin
        count <= count - QCntW'(1);
      end
    end
  end

  assign pop_item       = slots[rd_ptr];
  assign q_status.empty = (count == '0);
  assign q_status.full  = (count == QCntW'(QDepth));

endmodule

FILE: rtl/core/bdd_back.sv
// Frame engine: tracks the frame phase and errors, destuffs and registers each result.
// Depends on bdd_pkg and bdd_out_if.
`timescale 1ns / 1ps

module bdd_back import bdd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  item_t     pop_item,
  input  q_status_t q_status,
  output logic      pop,
  bdd_out_if.source out_ch
);

  phase_t            phase, phase_next;
  logic              start_bad, start_bad_next;
  err_t              body_err, body_err_next;
  logic [CountW-1:0] byte_count, byte_count_next;

  logic              res_data_valid;
  logic [ByteW-1:0]  res_data_byte;
  logic              res_done;
  err_t              res_code;
  logic [CountW-1:0] res_len;

  logic              out_valid;

  // Take the next item when the output register is free or being emptied.
  assign pop = !q_status.empty && (!out_valid || out_ch.ready);

  // Per-item state update and result.
  always_comb begin
    phase_next      = phase;
    start_bad_next  = start_bad;
    body_err_next   = body_err;
    byte_count_next = byte_count;
    res_data_valid  = 1'b0;
    res_done        = 1'b0;
    res_code        = ERR_NONE;

    if (pop_item.frame_end) begin
      // Closing byte: give the verdict and rearm.
      res_done = 1'b1;
      priority if (phase == PH_START) begin
        res_code = pop_item.is_flag ? ERR_NONE : ERR_FLAG;
      end else if (start_bad || !pop_item.is_flag) begin
        res_code = ERR_FLAG;
      end else if (body_err != ERR_NONE) begin
        res_code = body_err;
      end else if (phase == PH_ESC) begin
        res_code = ERR_DANGLING;
      end else begin
        res_code = ERR_NONE;
      end
      phase_next      = PH_START;
      start_bad_next  = 1'b0;
      body_err_next   = ERR_NONE;
      byte_count_next = '0;
    end else begin
      priority if (phase == PH_START) begin
        start_bad_next = !pop_item.is_flag;
        phase_next     = PH_BODY;
      end else if (body_err != ERR_NONE) begin
        // Frame already failed: ignore interior bytes.
      end else if (phase == PH_ESC) begin
        res_data_valid = 1'b1;
        phase_next     = PH_BODY;
      end else if (pop_item.is_esc) begin
        phase_next = PH_ESC;
      end else if (pop_item.is_flag) begin
        body_err_next = ERR_UNESCAPED;
      end else begin
        res_data_valid = 1'b1;
      end
      if (res_data_valid && (byte_count < CountW'(MaxPayload))) begin
        byte_count_next = byte_count + CountW'(1);
      end
    end

    res_data_byte = res_data_valid ? pop_item.rx_byte : '0;
    res_len       = pop_item.frame_end ? byte_count : byte_count_next;
  end

  // Frame state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      start_bad  <= 1'b0;
      body_err   <= ERR_NONE;
      byte_count <= '0;
    end else if (pop) begin
      phase      <= phase_next;
      start_bad  <= start_bad_next;
      body_err   <= body_err_next;
      byte_count <= byte_count_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      out_ch.data_valid     <= res_data_valid;
      out_ch.data_byte      <= res_data_byte;
      out_ch.frame_done     <= res_done;
      out_ch.frame_good     <= res_done && (res_code == ERR_NONE);
      out_ch.error_code     <= res_code;
      out_ch.payload_length <= LenW'(res_len);
    end
  end

  assign out_ch.valid = out_valid;

endmodule
